>>> rtl/rrr_pkg.sv
// Shared types and constants of the replica read router.
package rrr_pkg;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_LEADER = 2'd1;
   localparam logic [1:0] OP_ROUTE  = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   localparam logic [1:0] POL_LEADER = 2'd0;
   localparam logic [1:0] POL_RR     = 2'd1;
   localparam logic [1:0] POL_LEAST  = 2'd2;
   localparam logic [1:0] POL_RAND   = 2'd3;

   localparam logic [1:0] CSR_POLICY  = 2'd0;
   localparam logic [1:0] CSR_MAX_LAG = 2'd1;
   localparam logic [1:0] CSR_SLOTS   = 2'd2;

   localparam logic [31:0] SCATTER_MULT = 32'd2654435761;

   localparam int DIV_DIGITS = 4;
   localparam int DIV_STEPS  = 64 / DIV_DIGITS;
   localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_SEL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;      // capture the beat, apply slot and leader writes
      logic scan_clr;
      logic scan_step;
      logic div_load;
      logic div_rot;     // divide the rotation counter and advance it
      logic div_step;
      logic sel_step;
      logic res_leader;
      logic res_none;
      logic res_best;
      logic res_sel;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic count_zero;
      logic div_last;
      logic sel_hit;
   } sts_type;

endpackage

>>> rtl/rrr_ctrl.sv
// Controller state machine of the replica read router.
module rrr_ctrl (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [1:0]     req_op,
   input  logic [1:0]     policy,
   input  logic           out_free,
   output logic           out_load,
   output rrr_pkg::cmd_type cmd,
   input  rrr_pkg::sts_type sts
);

   rrr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         rrr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_op == rrr_pkg::OP_ROUTE && policy != rrr_pkg::POL_LEADER) begin
                  cmd.scan_clr = 1'b1;
                  state_in     = rrr_pkg::ST_SCAN;
               end else begin
                  cmd.res_leader = 1'b1;
                  state_in       = rrr_pkg::ST_DONE;
               end
            end
         end
         rrr_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (sts.count_zero) begin
                  cmd.res_none = 1'b1;
                  state_in     = rrr_pkg::ST_DONE;
               end else begin
                  unique case (policy)
                     rrr_pkg::POL_LEAST: begin
                        cmd.res_best = 1'b1;
                        state_in     = rrr_pkg::ST_DONE;
                     end
                     rrr_pkg::POL_RR: begin
                        cmd.div_load = 1'b1;
                        cmd.div_rot  = 1'b1;
                        state_in     = rrr_pkg::ST_DIV;
                     end
                     rrr_pkg::POL_RAND: begin
                        cmd.div_load = 1'b1;
                        state_in     = rrr_pkg::ST_DIV;
                     end
                     default: begin
                        cmd.res_none = 1'b1;
                        state_in     = rrr_pkg::ST_DONE;
                     end
                  endcase
               end
            end
         end
         rrr_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = rrr_pkg::ST_SEL;
            end
         end
         rrr_pkg::ST_SEL: begin
            cmd.sel_step = 1'b1;
            if (sts.sel_hit) begin
               cmd.res_sel = 1'b1;
               state_in    = rrr_pkg::ST_DONE;
            end
         end
         rrr_pkg::ST_DONE: begin
            out_load = out_free;
            if (out_free) begin
               state_in = rrr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/rrr_dp.sv
// Datapath of the replica read router: slot table, lag scan, modulo unit, pick.
module rrr_dp #(
   parameter int SLOT_COUNT = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  rrr_pkg::cmd_type cmd,
   output rrr_pkg::sts_type sts,
   input  logic [1:0]       req_op,
   input  logic [3:0]       req_slot_index,
   input  logic             req_slot_connected,
   input  logic             req_slot_streaming,
   input  logic             req_slot_has_store,
   input  logic [63:0]      req_position,
   input  logic [31:0]      req_time_seconds,
   input  logic [63:0]      max_lag,
   input  logic [4:0]       slots_in_use,
   input  logic             rot_clr,
   output logic             res_use_leader,
   output logic [3:0]       res_replica_index,
   output logic [4:0]       res_eligible_slots
);

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);

   logic [63:0]           pos_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] ok_ff;
   logic [SLOT_COUNT-1:0] elig_ff;
   logic [63:0]           leader_ff;
   logic [63:0]           rot_ff;
   logic [63:0]           prod_ff;

   logic [CW-1:0]  addr_ff;
   logic           s1_vld_ff, s2_vld_ff;
   logic [SW-1:0]  s1_idx_ff, s2_idx_ff;
   logic           s1_ok_ff, s2_ok_ff;
   logic [63:0]    pos_rd_ff, lag_ff;
   logic [CW-1:0]  count_ff;
   logic           have_ff;
   logic [63:0]    best_ff;
   logic [SW-1:0]  best_idx_ff;

   logic [63:0]    dvd_ff;
   logic [CW-1:0]  rem_ff, rem_in;
   logic [3:0]     step_ff;
   logic [CW-1:0]  sel_ff, rank_ff;

   logic [CW-1:0]  limit;
   logic           issue_go;
   logic [64:0]    diff;
   logic           eligible;
   logic [SW-1:0]  widx;

   assign limit = (32'(slots_in_use) > SLOT_COUNT) ? CW'(SLOT_COUNT) : CW'(slots_in_use);
   assign issue_go = cmd.scan_step && (addr_ff < limit);
   assign diff = {1'b0, leader_ff} - {1'b0, pos_rd_ff};
   assign eligible = s2_vld_ff && s2_ok_ff && (max_lag == 64'd0 || lag_ff <= max_lag);
   assign widx = SW'(req_slot_index);

   assign sts.scan_done  = !(addr_ff < limit) && !s1_vld_ff && !s2_vld_ff;
   assign sts.count_zero = (count_ff == '0);
   assign sts.div_last   = (step_ff == rrr_pkg::DIV_LAST);
   assign sts.sel_hit    = elig_ff[sel_ff[SW-1:0]] && (rank_ff == rem_ff);

   // take four quotient digits per cycle; only the remainder is kept
   always_comb begin
      logic [CW:0]  t;
      logic [63:0]  d;
      logic [CW-1:0] r;
      r = rem_ff;
      d = dvd_ff;
      for (int j = 0; j < rrr_pkg::DIV_DIGITS; j++) begin
         t = {r, d[63]};
         d = {d[62:0], 1'b0};
         if (t >= {1'b0, count_ff}) begin
            t = t - {1'b0, count_ff};
         end
         r = t[CW-1:0];
      end
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == rrr_pkg::OP_WRITE && 32'(req_slot_index) < SLOT_COUNT) begin
         pos_mem[widx] <= req_position;
      end
      pos_rd_ff <= pos_mem[addr_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff     <= '0;
         leader_ff <= '0;
         rot_ff    <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         addr_ff   <= '0;
         count_ff  <= '0;
         elig_ff   <= '0;
         have_ff   <= 1'b0;
      end else begin
         if (cmd.accept && req_op == rrr_pkg::OP_WRITE && 32'(req_slot_index) < SLOT_COUNT) begin
            ok_ff[widx] <= req_slot_connected & req_slot_streaming & req_slot_has_store;
         end
         if (cmd.accept && req_op == rrr_pkg::OP_LEADER) begin
            leader_ff <= req_position;
         end
         if (rot_clr) begin
            rot_ff <= '0;
         end else if (cmd.div_load && cmd.div_rot) begin
            rot_ff <= rot_ff + 64'd1;
         end
         if (cmd.scan_clr) begin
            addr_ff   <= '0;
            s1_vld_ff <= 1'b0;
            s2_vld_ff <= 1'b0;
            count_ff  <= '0;
            elig_ff   <= '0;
            have_ff   <= 1'b0;
         end else begin
            s1_vld_ff <= issue_go;
            s2_vld_ff <= s1_vld_ff;
            if (issue_go) begin
               addr_ff <= addr_ff + CW'(1);
            end
            if (eligible) begin
               count_ff           <= count_ff + CW'(1);
               elig_ff[s2_idx_ff] <= 1'b1;
               have_ff            <= 1'b1;
            end
         end
      end
   end

   // payload side of the scan, modulo unit and pick search
   always_ff @(posedge clock) begin
      s1_idx_ff <= addr_ff[SW-1:0];
      s1_ok_ff  <= ok_ff[addr_ff[SW-1:0]];
      s2_idx_ff <= s1_idx_ff;
      s2_ok_ff  <= s1_ok_ff;
      lag_ff    <= diff[64] ? 64'd0 : diff[63:0];
      if (eligible && (!have_ff || lag_ff < best_ff)) begin
         best_ff     <= lag_ff;
         best_idx_ff <= s2_idx_ff;
      end
      if (cmd.accept) begin
         prod_ff <= 64'(req_time_seconds) * 64'(rrr_pkg::SCATTER_MULT);
      end
      if (cmd.div_load) begin
         dvd_ff  <= cmd.div_rot ? rot_ff : prod_ff;
         rem_ff  <= '0;
         step_ff <= '0;
         sel_ff  <= '0;
         rank_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= dvd_ff << rrr_pkg::DIV_DIGITS;
         rem_ff  <= rem_in;
         step_ff <= step_ff + 4'd1;
      end else if (cmd.sel_step && !sts.sel_hit) begin
         sel_ff <= sel_ff + CW'(1);
         if (elig_ff[sel_ff[SW-1:0]]) begin
            rank_ff <= rank_ff + CW'(1);
         end
      end
      if (cmd.res_leader) begin
         res_use_leader     <= 1'b1;
         res_replica_index  <= 4'd0;
         res_eligible_slots <= 5'd0;
      end else if (cmd.res_none) begin
         res_use_leader     <= 1'b1;
         res_replica_index  <= 4'd0;
         res_eligible_slots <= 5'(count_ff);
      end else if (cmd.res_best) begin
         res_use_leader     <= 1'b0;
         res_replica_index  <= 4'(best_idx_ff);
         res_eligible_slots <= 5'(count_ff);
      end else if (cmd.res_sel) begin
         res_use_leader     <= 1'b0;
         res_replica_index  <= 4'(sel_ff[SW-1:0]);
         res_eligible_slots <= 5'(count_ff);
      end
   end

endmodule

>>> rtl/replica_read_router.sv
// Top level of the replica read router: configuration, controller, datapath, output beat.
// Each request beat writes a replica slot, sets the leader log position, or routes a read.
// Slot and leader writes, leader-only reads and unused op codes settle their answer when
// the request beat is taken and load it into the output register once that is free. A
// routed read scans the slots in use one per cycle through a three-stage read, lag and
// compare pipe; least lag answers once the scan has drained, while round robin and pseudo
// random then run a 64-bit modulo unit that retires four bits a cycle and walk the slots
// one per cycle, counting the eligible ones, to find the pick.
// One request is in flight at a time; the next request beat is taken as soon as the result
// sits in the output register.
// A slot is eligible when it is connected, streaming and has a store and its lag behind
// the leader (clamped at zero) is within max_lag, where a max_lag of zero means no limit.
// Write configuration only while the block is idle; a policy write clears the rotation.
module replica_read_router #(
   parameter int SLOT_COUNT = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // op[1:0], slot_index[5:2], slot_connected[6], slot_streaming[7],
   // slot_has_store[8], position[72:9], time_seconds[104:73], zero fill
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // use_leader[0], replica_index[4:1], eligible_slots[9:5], zero fill
   output logic [15:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_wdata
);

   logic [1:0]  policy_ff;
   logic [63:0] max_lag_ff;
   logic [4:0]  slots_ff;
   logic        rot_clr;

   rrr_pkg::cmd_type cmd;
   rrr_pkg::sts_type sts;

   logic        out_free, out_load;
   logic        rsp_vld_ff;
   logic [15:0] rsp_data_ff;
   logic        res_use_leader;
   logic [3:0]  res_replica_index;
   logic [4:0]  res_eligible_slots;

   // configuration registers; unknown indexes are dropped
   assign rot_clr = csr_we && (csr_index == rrr_pkg::CSR_POLICY);

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= rrr_pkg::POL_LEADER;
         max_lag_ff <= '0;
         slots_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rrr_pkg::CSR_POLICY:  policy_ff  <= csr_wdata[1:0];
            rrr_pkg::CSR_MAX_LAG: max_lag_ff <= csr_wdata;
            rrr_pkg::CSR_SLOTS:   slots_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   rrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tdata[1:0]),
      .policy     (policy_ff),
      .out_free   (out_free),
      .out_load   (out_load),
      .cmd        (cmd),
      .sts        (sts)
   );

   rrr_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_op             (req_tdata[1:0]),
      .req_slot_index     (req_tdata[5:2]),
      .req_slot_connected (req_tdata[6]),
      .req_slot_streaming (req_tdata[7]),
      .req_slot_has_store (req_tdata[8]),
      .req_position       (req_tdata[72:9]),
      .req_time_seconds   (req_tdata[104:73]),
      .max_lag            (max_lag_ff),
      .slots_in_use       (slots_ff),
      .rot_clr            (rot_clr),
      .res_use_leader     (res_use_leader),
      .res_replica_index  (res_replica_index),
      .res_eligible_slots (res_eligible_slots)
   );

   // output beat register: hold until taken, load when free
   assign out_free = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {6'd0, res_eligible_slots, res_replica_index, res_use_leader};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a request is in flight");

   a_replica_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[9:5] != 5'd0))
      else $error("replica chosen with no eligible slot");

   a_leader_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[4:1] == 4'd0))
      else $error("leader result carries a replica index");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (sts.sel_hit && cmd.sel_step) |-> !sts.count_zero)
      else $error("pick search hit with an empty eligible set");

endmodule

>>> bench/tb_replica_read_router.sv
// Testbench of the replica read router: directed table, random traffic, predictor check.
`timescale 1ns / 100ps

module tb_replica_read_router;

   localparam int SLOTS = 16;
   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT = 400000;

   // one route or write request as the block sees it
   typedef struct {
      logic [1:0]  op;
      logic [3:0]  slot;
      logic        conn;
      logic        strm;
      logic        store;
      logic [63:0] pos;
      logic [31:0] secs;
   } request_type;

   // one routing answer
   typedef struct packed {
      logic       use_leader;
      logic [3:0] replica;
      logic [4:0] count;
   } answer_type;

   // directed row: a request, plus an answer typed in where it is obvious
   typedef struct {
      request_type req;
      logic        known;
      answer_type  ans;
   } row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [15:0]   rsp_tdata;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = rrr_pkg::CSR_POLICY;
   logic [63:0]   csr_wdata = '0;

   replica_read_router #(.SLOT_COUNT(SLOTS)) i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the block's state and registers
   logic        tbl_conn [SLOTS];
   logic        tbl_strm [SLOTS];
   logic        tbl_store [SLOTS];
   logic [63:0] tbl_pos [SLOTS];
   logic [63:0] leader_pos;
   logic [63:0] rotation;
   logic [1:0]  policy;
   logic [63:0] lag_limit;
   logic [4:0]  slots_used;

   answer_type  pending_answers[$];
   int          fail_count = 0;
   int          answers_seen = 0;
   int          routes_sent = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   function automatic logic [63:0] lag_of(int s);
      return leader_pos > tbl_pos[s] ? leader_pos - tbl_pos[s] : 64'd0;
   endfunction

   // apply one request to the predictor state and return its answer
   function automatic answer_type route_answer(request_type r);
      answer_type a;
      int list[$];
      int lim;
      int pick;
      logic [63:0] best;
      logic [63:0] prod;
      a.use_leader = 1'b1;
      a.replica = '0;
      a.count = '0;
      if (r.op == rrr_pkg::OP_WRITE) begin
         tbl_conn[r.slot] = r.conn;
         tbl_strm[r.slot] = r.strm;
         tbl_store[r.slot] = r.store;
         tbl_pos[r.slot] = r.pos;
         return a;
      end
      if (r.op == rrr_pkg::OP_LEADER) begin
         leader_pos = r.pos;
         return a;
      end
      if (r.op != rrr_pkg::OP_ROUTE || policy == rrr_pkg::POL_LEADER) return a;
      lim = slots_used > SLOTS ? SLOTS : slots_used;
      for (int s = 0; s < lim; s++)
         if (tbl_conn[s] && tbl_strm[s] && tbl_store[s] &&
             (lag_limit == 0 || lag_of(s) <= lag_limit))
            list.push_back(s);
      a.count = 5'(list.size());
      if (list.size() == 0) return a;
      pick = 0;
      if (policy == rrr_pkg::POL_RR) begin
         pick = int'(rotation % 64'(list.size()));
         rotation = rotation + 1;
      end else if (policy == rrr_pkg::POL_LEAST) begin
         best = '1;
         foreach (list[i])
            if (lag_of(list[i]) < best) begin
               best = lag_of(list[i]);
               pick = i;
            end
      end else begin
         prod = 64'(r.secs) * 64'(rrr_pkg::SCATTER_MULT);
         pick = int'(prod % 64'(list.size()));
      end
      a.use_leader = 1'b0;
      a.replica = 4'(list[pick]);
      return a;
   endfunction

   // check each answer beat against the oldest expectation
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            $error("answer beat with nothing expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[0] !== want.use_leader) begin
               $error("use_leader: expected %0d, got %0d", want.use_leader, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[4:1] !== want.replica) begin
               $error("replica_index: expected %0d, got %0d", want.replica, rsp_tdata[4:1]);
               fail_count++;
            end
            if (rsp_tdata[9:5] !== want.count) begin
               $error("eligible_slots: expected %0d, got %0d", want.count, rsp_tdata[9:5]);
               fail_count++;
            end
         end
      end
   end

   // receiver stalls at the current rate, driven on the falling edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == rrr_pkg::CSR_POLICY) begin
         policy = val[1:0];
         rotation = '0;
      end else if (idx == rrr_pkg::CSR_MAX_LAG) begin
         lag_limit = val;
      end else begin
         slots_used = val[4:0];
      end
   endtask

   // wait for every answer, then let the block settle before touching registers
   task automatic drain();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // drive one request beat; hold it until taken, optionally with a typed answer
   task automatic send_request(request_type r, logic known, answer_type typed);
      answer_type a;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tdata <= {7'd0, r.secs, r.pos, r.store, r.strm, r.conn, r.slot, r.op};
      req_tvalid <= 1'b1;
      a = route_answer(r);
      if (known && a != typed) begin
         $error("directed row disagrees with predictor for op %0d", r.op);
         fail_count++;
      end
      pending_answers.push_back(known ? typed : a);
      if (r.op == rrr_pkg::OP_ROUTE) routes_sent++;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   function automatic request_type make_req(logic [1:0] op, logic [3:0] slot, logic [2:0] flags,
                                            logic [63:0] pos, logic [31:0] secs);
      request_type r;
      r.op = op;
      r.slot = slot;
      {r.store, r.strm, r.conn} = flags;
      r.pos = pos;
      r.secs = secs;
      return r;
   endfunction

   function automatic row_type row(request_type r, logic known, logic ul, logic [3:0] ri,
                                   logic [4:0] ec);
      row_type w;
      w.req = r;
      w.known = known;
      w.ans.use_leader = ul;
      w.ans.replica = ri;
      w.ans.count = ec;
      return w;
   endfunction

   // random request: mostly slot writes and routes with positions near the leader
   function automatic request_type random_req(int pos_span);
      request_type r;
      int pick;
      pick = $urandom_range(99);
      r.op = pick < 40 ? rrr_pkg::OP_WRITE : pick < 50 ? rrr_pkg::OP_LEADER :
             pick < 97 ? rrr_pkg::OP_ROUTE : rrr_pkg::OP_SPARE;
      r.slot = 4'($urandom_range(SLOTS - 1));
      r.conn = ($urandom_range(9) != 0);
      r.strm = ($urandom_range(9) != 0);
      r.store = ($urandom_range(9) != 0);
      if ($urandom_range(19) == 0)
         r.pos = {$urandom, $urandom};
      else
         r.pos = leader_pos + 64'($urandom_range(2 * pos_span)) - 64'(pos_span);
      r.secs = $urandom;
      return r;
   endfunction

   row_type     directed[$];
   answer_type  none;

   initial begin
      logic [63:0] lag_pick;
      none = '{1'b1, 4'd0, 5'd0};
      foreach (tbl_conn[s]) begin
         tbl_conn[s] = 0;
         tbl_strm[s] = 0;
         tbl_store[s] = 0;
         tbl_pos[s] = '0;
      end
      leader_pos = '0;
      rotation = '0;
      policy = rrr_pkg::POL_LEADER;
      lag_limit = '0;
      slots_used = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: leader-only policy answers the leader for every op
      directed.push_back(row(make_req(rrr_pkg::OP_ROUTE, 4'd0, 3'b111, '0, '1), 1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_SPARE, 4'd15, 3'b111, '1, '1), 1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_WRITE, 4'd0, 3'b111, 64'd100, '0),
                             1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_WRITE, 4'd15, 3'b111, '1, '1), 1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_WRITE, 4'd3, 3'b011, 64'd5, '0), 1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_WRITE, 4'd4, 3'b101, 64'd5, '0), 1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_WRITE, 4'd5, 3'b110, 64'd5, '0), 1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_WRITE, 4'd7, 3'b111, 64'd90, '0),
                             1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_LEADER, 4'd0, 3'b000, 64'd120, '0),
                             1, 1, 0, 0));
      directed.push_back(row(make_req(rrr_pkg::OP_ROUTE, 4'd0, 3'b000, '0, 32'd7), 1, 1, 0, 0));
      foreach (directed[i])
         send_request(directed[i].req, directed[i].known, directed[i].ans);
      drain();

      // walk the round robin, least lag and random policies over the same table, with and
      // without a lag limit; slots_in_use above the slot count is clamped
      write_csr(rrr_pkg::CSR_SLOTS, 5'd31);
      for (int p = 1; p < 4; p++) begin
         write_csr(rrr_pkg::CSR_POLICY, 2'(p));
         write_csr(rrr_pkg::CSR_MAX_LAG, (p == 2) ? 64'd25 : 64'd0);
         for (int k = 0; k < 4; k++)
            send_request(make_req(rrr_pkg::OP_ROUTE, 4'd0, 3'b000, '0,
                                  k == 3 ? '1 : 32'(k)), 0, none);
         drain();
      end
      // huge leader position: lags grow large, max_lag all ones admits everyone
      write_csr(rrr_pkg::CSR_MAX_LAG, '1);
      send_request(make_req(rrr_pkg::OP_LEADER, 4'd0, 3'b000, '1, '0), 1, none);
      send_request(make_req(rrr_pkg::OP_ROUTE, 4'd0, 3'b000, '0, '1), 0, none);
      drain();
      write_csr(rrr_pkg::CSR_MAX_LAG, 64'd1);
      send_request(make_req(rrr_pkg::OP_ROUTE, 4'd0, 3'b000, '0, '0), 0, none);
      drain();

      // random phases: register settings change between phases, idling as planned
      for (int ph = 0; ph < 12; ph++) begin
         send_idle_pct = ph < 4 ? 31 : ph < 8 ? 54 : 0;
         recv_idle_pct = ph < 4 ? 54 : ph < 8 ? 31 : 0;
         write_csr(rrr_pkg::CSR_POLICY, 2'(ph % 4 == 0 ? $urandom_range(3) : ph % 4));
         case ($urandom_range(3))
            0: lag_pick = '0;
            1: lag_pick = '1;
            default: lag_pick = 64'($urandom_range(400));
         endcase
         write_csr(rrr_pkg::CSR_MAX_LAG, lag_pick);
         write_csr(rrr_pkg::CSR_SLOTS, ph == 3 ? 5'd0 : ph == 5 ? 5'd16 :
                   5'($urandom_range(ph % 2 ? 31 : 16)));
         for (int n = 0; n < RANDOM_ITEMS / 12; n++)
            send_request(random_req(300), 0, none);
         drain();
      end

      $display("covered %0d answers (%0d route requests) across all policies and lag limits",
               answers_seen, routes_sent);
      if (fail_count == 0 && pending_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
